// ----- src/tup_pkg.sv -----
// ----------------------------------------------------------------------------
// tup_pkg
// Shared types, codes and constants of the texel unpack unit: payload
// structs, colour format codes, register indexes and the job record that
// passes from the front part to the back part.
// ----------------------------------------------------------------------------
package tup_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COLOUR_FORMAT = 2'd0,
		CFG_OPAQUE_ALPHA  = 2'd1
	} cfg_index_t;

	// colour format codes, codes 5..7 mean nothing
	typedef enum logic [2:0] {
		FMT_565    = 3'd0,
		FMT_555    = 3'd1,
		FMT_1555   = 3'd2,
		FMT_4444   = 3'd3,
		FMT_YUV422 = 3'd4
	} colour_format_t;

	localparam colour_format_t COLOUR_FORMAT_RESET = FMT_565;
	localparam logic [7:0]     OPAQUE_ALPHA_RESET  = 8'd255;

	// default depth of the job queue
	localparam int TUP_QUEUE_DEPTH = 2;

	// input item
	typedef struct packed {
		logic [15:0] texel_word;
		logic        column_odd;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] alpha_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       from_held_pixel;
		logic       last_of_run;
	} out_item_t;

	// job classes
	typedef enum logic {
		JOB_DIRECT = 1'b0,
		JOB_YUV    = 1'b1
	} job_kind_t;

	// one job for the back part
	typedef struct packed {
		job_kind_t      kind;
		colour_format_t fmt;
		logic [7:0]     alpha;
		logic [15:0]    texel;
		logic [15:0]    held;
	} job_t;

	// job channel between front, queue and back
	typedef struct packed {
		logic valid;
		job_t job;
	} job_chan_t;

endpackage

// ----- src/texel_unpack_argb_yuv422_unit.sv -----
// ----------------------------------------------------------------------------
// texel_unpack_argb_yuv422_unit
// Path: a texel's first result passes the job queue and the output register;
// the second pixel of a yuv pair follows the first.
// Throughput: one texel per cycle while the queue is not full; a yuv odd
// texel holds the back part for its two pixels, one per cycle while the
// output does not stall. The job queue (QUEUE_DEPTH entries) absorbs the wait.
// Reset: format 565, opaque alpha 255, held yuv word zero, queue empty.
// ----------------------------------------------------------------------------
module texel_unpack_argb_yuv422_unit
	import tup_pkg::*;
#(
	parameter int QUEUE_DEPTH = TUP_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	job_chan_t push;
	job_chan_t head;
	logic      queue_full;
	logic      pop;

	// front: accept and classify
	tup_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push)
	);

	// job queue
	tup_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	// back: convert and deliver
	tup_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- src/tup_front.sv -----
// ----------------------------------------------------------------------------
// tup_front
// Accepts texels, keeps the configuration registers and the held yuv even
// word, and turns each texel that gives results into a job for the queue.
// ----------------------------------------------------------------------------
module tup_front
	import tup_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   queue_full,
	output job_chan_t              push
);

	colour_format_t colour_format_q;
	logic [7:0]     opaque_alpha_q;
	logic [15:0]    held_even_word_q;
	logic           accept;
	logic           is_even_yuv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_format_q <= COLOUR_FORMAT_RESET;
			opaque_alpha_q  <= OPAQUE_ALPHA_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_COLOUR_FORMAT: colour_format_q <= colour_format_t'(cfg_data[2:0]);
				CFG_OPAQUE_ALPHA:  opaque_alpha_q  <= cfg_data[7:0];
				default:           ;
			endcase
		end
	end

	// input handshake
	assign in_stall    = queue_full;
	assign accept      = in_valid && !in_stall;
	assign is_even_yuv = (colour_format_q == FMT_YUV422) && !in_data.column_odd;

	// held yuv even word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_even_word_q <= '0;
		end else if (accept && is_even_yuv) begin
			held_even_word_q <= in_data.texel_word;
		end
	end

	// classify the texel into a job
	always_comb begin
		push.valid     = 1'b0;
		push.job.kind  = JOB_DIRECT;
		push.job.fmt   = colour_format_q;
		push.job.alpha = opaque_alpha_q;
		push.job.texel = in_data.texel_word;
		push.job.held  = held_even_word_q;
		unique case (colour_format_q) inside
			FMT_565, FMT_555, FMT_1555, FMT_4444: begin
				push.valid = accept;
			end
			FMT_YUV422: begin
				push.valid    = accept && in_data.column_odd;
				push.job.kind = JOB_YUV;
			end
			default: begin
				push.valid = 1'b0;
			end
		endcase
	end

endmodule

// ----- src/tup_queue.sv -----
// ----------------------------------------------------------------------------
// tup_queue
// Short register queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module tup_queue
	import tup_pkg::*;
#(
	parameter int DEPTH = TUP_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_chan_t push,
	output logic      full,
	output job_chan_t head,
	input  logic      pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == FULL_CNT);
	assign do_push  = push.valid && !full;
	assign do_pop   = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.job   = store_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push.job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/tup_back.sv -----
// ----------------------------------------------------------------------------
// tup_back
// Carries out jobs: unpacks direct formats and converts yuv pairs to two
// rgb pixels, held pixel first, into the output register.
// ----------------------------------------------------------------------------
module tup_back
	import tup_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_chan_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic             out_valid_q;
	out_item_t        out_q;
	logic             second_q;
	logic             load;
	logic             first_of_pair;
	out_item_t        result;
	logic [7:0]       y_sel;
	logic signed [8:0]  du;
	logic signed [8:0]  dv;
	logic signed [14:0] y_x32;
	logic signed [14:0] du_x;
	logic signed [14:0] dv_x;
	logic signed [14:0] r_sum;
	logic signed [14:0] g_sum;
	logic signed [14:0] b_sum;

	// truncate the 5-fraction-bit sum and clamp to 0..255
	function automatic logic [7:0] clamp_fixed(input logic signed [14:0] sum);
		logic [9:0] whole;
		whole = sum[14:5];
		if (sum <= 15'sd0) begin
			return 8'd0;
		end else if (whole > 10'd255) begin
			return 8'd255;
		end else begin
			return whole[7:0];
		end
	endfunction

	assign first_of_pair = (head.job.kind == JOB_YUV) && !second_q;
	assign load          = head.valid && (!out_valid_q || !out_stall);
	assign pop           = load && !first_of_pair;

	// yuv arithmetic, exact in fixed point
	always_comb begin
		y_sel = second_q ? head.job.texel[15:8] : head.job.held[15:8];
		du    = $signed({1'b0, head.job.held[7:0]}) - 9'sd128;
		dv    = $signed({1'b0, head.job.texel[7:0]}) - 9'sd128;
		y_x32 = $signed({2'b00, y_sel, 5'b00000});
		du_x  = {{6{du[8]}}, du};
		dv_x  = {{6{dv[8]}}, dv};
		r_sum = y_x32 + dv_x * 15'sd44;
		g_sum = y_x32 - dv_x * 15'sd22 - du_x * 15'sd11;
		b_sum = y_x32 + du_x * 15'sd55;
	end

	// result for the job at the head of the queue
	always_comb begin
		result.alpha_out       = head.job.alpha;
		result.red_out         = '0;
		result.green_out       = '0;
		result.blue_out        = '0;
		result.from_held_pixel = 1'b0;
		result.last_of_run     = 1'b1;
		if (head.job.kind == JOB_YUV) begin
			result.red_out         = clamp_fixed(r_sum);
			result.green_out       = clamp_fixed(g_sum);
			result.blue_out        = clamp_fixed(b_sum);
			result.from_held_pixel = first_of_pair;
			result.last_of_run     = !first_of_pair;
		end else begin
			unique case (head.job.fmt)
				FMT_565: begin
					result.red_out   = {head.job.texel[15:11], 3'b000};
					result.green_out = {head.job.texel[10:5], 2'b00};
					result.blue_out  = {head.job.texel[4:0], 3'b000};
				end
				FMT_555: begin
					result.red_out   = {head.job.texel[14:10], 3'b000};
					result.green_out = {head.job.texel[9:5], 3'b000};
					result.blue_out  = {head.job.texel[4:0], 3'b000};
				end
				FMT_1555: begin
					result.alpha_out = {8{head.job.texel[15]}};
					result.red_out   = {head.job.texel[14:10], 3'b000};
					result.green_out = {head.job.texel[9:5], 3'b000};
					result.blue_out  = {head.job.texel[4:0], 3'b000};
				end
				FMT_4444: begin
					result.alpha_out = {head.job.texel[15:12], 4'b0000};
					result.red_out   = {head.job.texel[11:8], 4'b0000};
					result.green_out = {head.job.texel[7:4], 4'b0000};
					result.blue_out  = {head.job.texel[3:0], 4'b0000};
				end
				default: begin
					result.alpha_out = head.job.alpha;
				end
			endcase
		end
	end

	// output register and pair phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			second_q    <= first_of_pair;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
